// ----- hdl/adaptive_microstep_indexer_defines.svh -----
// Assertion macros used by the adaptive microstep indexer core
`ifndef ADAPTIVE_MICROSTEP_INDEXER_DEFINES_SVH
`define ADAPTIVE_MICROSTEP_INDEXER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define AMI_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("indexer check failed");

// Next-cycle implication, checked outside reset
`define AMI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("indexer check failed");

`endif

// ----- hdl/ami_pkg.sv -----
// Types and constants of the adaptive microstep indexer
`timescale 1ns / 1ps

package ami_pkg;

    localparam int MODE_W     = 4;
    localparam int ERR_W      = 24;
    localparam int DELTA_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_ENABLE       = 2'd0,
        REG_ADAPTIVE_ENABLE   = 2'd1,
        REG_FINEST_MODE       = 2'd2,
        REG_REVERSE_DIRECTION = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              axis_en;
        logic              adapt_en;
        logic              reverse;
        logic              init;
        logic [MODE_W-1:0] init_mode;
    } cfg_ctrl_t;

endpackage

// ----- hdl/ami_cfg.sv -----
// Configuration register file of the microstep indexer
`timescale 1ns / 1ps

module ami_cfg import ami_pkg::*; #(
    parameter int MAX_MODE = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_ctrl_t             ctrl
);

    logic axis_reg, axis_next;
    logic adapt_reg, adapt_next;
    logic rev_reg, rev_next;
    logic wr;
    logic init_hit;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb begin
        axis_next  = axis_reg;
        adapt_next = adapt_reg;
        rev_next   = rev_reg;
        init_hit   = 1'b0;
        if (wr) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AXIS_ENABLE:       axis_next  = cfg_data[0];
                REG_ADAPTIVE_ENABLE:   adapt_next = cfg_data[0];
                REG_FINEST_MODE:       init_hit   = 1'b1;
                REG_REVERSE_DIRECTION: rev_next   = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg  <= 1'b0;
            adapt_reg <= 1'b0;
            rev_reg   <= 1'b0;
        end else begin
            axis_reg  <= axis_next;
            adapt_reg <= adapt_next;
            rev_reg   <= rev_next;
        end
    end

    // saturate the finest mode to the supported range
    assign ctrl.axis_en   = axis_reg;
    assign ctrl.adapt_en  = adapt_reg;
    assign ctrl.reverse   = rev_reg;
    assign ctrl.init      = init_hit;
    assign ctrl.init_mode = (MODE_W'(cfg_data) > MODE_W'(MAX_MODE)) ?
                            MODE_W'(MAX_MODE) : MODE_W'(cfg_data);

endmodule

// ----- hdl/ami_core.sv -----
// Indexer datapath: input register, adaptation and step logic, result register
`timescale 1ns / 1ps

module ami_core import ami_pkg::*; #(
    parameter int MAX_MODE        = 8,
    parameter int POSITION_WIDTH  = 32,
    parameter int ERROR_FRAC_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_ctrl_t                 ctrl,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ERR_W-1:0]   s_position_error,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_step_taken,
    output logic                      m_direction_bit,
    output logic signed [DELTA_W-1:0] m_step_delta,
    output logic [MODE_W-1:0]         m_current_mode
);
    `include "adaptive_microstep_indexer_defines.svh"

    localparam int SIZE_W = MAX_MODE + 1;
    localparam int SQ_W   = SIZE_W + ERROR_FRAC_BITS;
    localparam int CMP_W  = ((SQ_W + 2 > ERR_W + 3) ? SQ_W + 2 : ERR_W + 3) + 1;

    // input stage
    logic                     in_valid_reg, in_valid_next;
    logic [ERR_W-1:0]         err_reg;
    // indexer state
    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [SIZE_W-1:0]        size_reg, size_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    // result stage
    logic                     out_valid_reg, out_valid_next;
    logic                     taken_reg;
    logic                     dir_reg;
    logic [DELTA_W-1:0]       delta_reg;
    logic [MODE_W-1:0]        cmode_reg;

    logic                     out_free;
    logic                     advance;
    logic [ERR_W-1:0]         mag;
    logic [CMP_W-1:0]         mag_x, mag2, mag5, sq_old, thr3, sq_new;
    logic                     aligned, coarsen, refine, over, fwd, bwd;
    logic [SIZE_W-1:0]        size_adj;
    logic [MODE_W-1:0]        mode_adj;
    logic [DELTA_W-1:0]       dmag, delta;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // magnitude of the Q-format error; the most negative code maps to 2^23
    assign mag   = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign mag_x = CMP_W'(mag);
    assign mag2  = mag_x << 1;
    assign mag5  = mag_x + (mag_x << 2);

    assign sq_old  = CMP_W'(size_reg) << ERROR_FRAC_BITS;
    assign thr3    = sq_old + (sq_old << 1);
    assign aligned = (pos_reg[SIZE_W-1:0] & size_reg) == '0;

    always_comb begin
        coarsen = ctrl.axis_en && ctrl.adapt_en && (mag_x > thr3) && aligned &&
                  (mode_reg != '0) && !size_reg[SIZE_W-1];
        refine  = ctrl.axis_en && ctrl.adapt_en && !coarsen && (mag5 <= thr3) &&
                  (size_reg[SIZE_W-1:1] != '0) && (mode_reg < MODE_W'(MAX_MODE));
        size_adj = size_reg;
        mode_adj = mode_reg;
        if (coarsen) begin
            size_adj = size_reg << 1;
            mode_adj = mode_reg - 1'b1;
        end else if (refine) begin
            size_adj = size_reg >> 1;
            mode_adj = mode_reg + 1'b1;
        end
    end

    // step decision against the adapted step size
    assign sq_new = CMP_W'(size_adj) << ERROR_FRAC_BITS;
    assign over   = mag2 > sq_new;
    assign fwd    = ctrl.axis_en && !err_reg[ERR_W-1] && over;
    assign bwd    = ctrl.axis_en && err_reg[ERR_W-1] && over;
    assign dmag   = DELTA_W'(size_adj);

    always_comb begin
        if (fwd) begin
            delta = dmag;
        end else if (bwd) begin
            delta = ~dmag + 1'b1;
        end else begin
            delta = '0;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        size_next = size_reg;
        pos_next  = pos_reg;
        if (ctrl.init) begin
            mode_next = ctrl.init_mode;
            size_next = SIZE_W'(1);
            pos_next  = '0;
        end else if (advance) begin
            mode_next = mode_adj;
            size_next = size_adj;
            if (fwd) begin
                pos_next = pos_reg + POSITION_WIDTH'(size_adj);
            end else if (bwd) begin
                pos_next = pos_reg - POSITION_WIDTH'(size_adj);
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_W'(MAX_MODE);
            size_reg      <= SIZE_W'(1);
            pos_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            size_reg      <= size_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            err_reg <= s_position_error;
        end
        if (advance) begin
            taken_reg <= fwd || bwd;
            dir_reg   <= (fwd && !ctrl.reverse) || (bwd && ctrl.reverse);
            delta_reg <= delta;
            cmode_reg <= mode_adj;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_step_taken    = taken_reg;
    assign m_direction_bit = dir_reg;
    assign m_step_delta    = delta_reg;
    assign m_current_mode  = cmode_reg;

    `AMI_ASSERT_NOW(a_size_onehot, aclk, aresetn, 1'b1, $onehot(size_reg))
    `AMI_ASSERT_NOW(a_delta_taken, aclk, aresetn, out_valid_reg,
                    taken_reg == (delta_reg != '0))
    `AMI_ASSERT_NEXT(a_hold_state, aclk, aresetn, out_valid_reg && !m_ready && !ctrl.init,
                     $stable(pos_reg) && $stable(size_reg) && $stable(mode_reg))

endmodule

// ----- hdl/adaptive_microstep_indexer.sv -----
// Adaptive microstep indexer: top level with configuration port and tick channels
`timescale 1ns / 1ps

// One position-error beat is taken every clock cycle while the result side does not
// stall. Its result passes through the input register, then the result register,
// before it is presented on the result port. The indexer state (mode, step size,
// position) is updated in the cycle
// a beat moves from the input register to the result register, so consecutive
// ticks see each other's effect with no bubble; throughput drops only when the
// result side stalls. The configuration port is always ready and takes effect at
// once; write it only while no tick is in flight. A write of finest_mode (saturated
// to MAX_MODE) also returns the mode to that value, the step size to one and the
// position to zero. An item sets no step when axis_enable is low, but a result
// carrying the current mode is still returned.

module adaptive_microstep_indexer import ami_pkg::*; #(
    parameter int MAX_MODE        = 8,
    parameter int POSITION_WIDTH  = 32,
    parameter int ERROR_FRAC_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ERR_W-1:0]   s_position_error,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_step_taken,
    output logic                      m_direction_bit,
    output logic signed [DELTA_W-1:0] m_step_delta,
    output logic [MODE_W-1:0]         m_current_mode
);

    cfg_ctrl_t ctrl;

    ami_cfg #(
        .MAX_MODE (MAX_MODE)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl)
    );

    ami_core #(
        .MAX_MODE        (MAX_MODE),
        .POSITION_WIDTH  (POSITION_WIDTH),
        .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_position_error (s_position_error),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_taken     (m_step_taken),
        .m_direction_bit  (m_direction_bit),
        .m_step_delta     (m_step_delta),
        .m_current_mode   (m_current_mode)
    );

endmodule
